/* hdl/jacs_pkg.sv */
// ----------------------------------------------------------------------------
// jacs_pkg
// shared constants, operation codes and divider handshake types for the
// joystick axis calibrate and scale block
// ----------------------------------------------------------------------------
package jacs_pkg;

  localparam int unsigned CHANNELS_DEF = 4;

  // operation codes
  localparam logic [1:0] OP_CONVERT = 2'd0;
  localparam logic [1:0] OP_CAPTURE = 2'd1;
  localparam logic [1:0] OP_TRACK   = 2'd2;
  localparam logic [1:0] OP_FINISH  = 2'd3;

  // full-scale magnitude, also the dividend of the gain division
  localparam int unsigned QUO_W      = 15;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

  localparam logic [QUO_W-1:0]   FULL_SCALE  = 15'h7fff;
  localparam logic signed [15:0] AXIS_POS    = 16'sh7fff;
  localparam logic signed [15:0] AXIS_NEG    = -16'sh7fff;
  localparam logic signed [15:0] RANGE_MIN_RST = 16'sh7fff;
  localparam logic signed [15:0] RANGE_MAX_RST = 16'sh8000;
  localparam logic signed [15:0] GAIN_RST      = 16'sd1;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hdl/jacs_if.sv */
// ----------------------------------------------------------------------------
// jacs_if
// valid/ready channels for samples going in and scaled results coming out
// ----------------------------------------------------------------------------
interface jacs_samp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  channel;
  logic [15:0] raw_sample;

  modport source (output valid, output operation, output channel, output raw_sample,
                  input ready);
  modport sink   (input valid, input operation, input channel, input raw_sample,
                  output ready);
endinterface

interface jacs_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_value;
  logic signed [15:0] neg_gain_out;
  logic signed [15:0] pos_gain_out;
  logic               divide_by_zero;

  modport source (output valid, output axis_value, output neg_gain_out,
                  output pos_gain_out, output divide_by_zero, input ready);
  modport sink   (input valid, input axis_value, input neg_gain_out,
                  input pos_gain_out, input divide_by_zero, output ready);
endinterface

/* hdl/jacs_div.sv */
// ----------------------------------------------------------------------------
// jacs_div
// restoring divider, full scale over a 17-bit magnitude, one quotient bit
// per cycle
// ----------------------------------------------------------------------------
module jacs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jacs_pkg::div_req_t req_i,
  output jacs_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [jacs_pkg::STEP_CNT_W-1:0]     cnt_q, cnt_d;
  logic [jacs_pkg::MAG_W-1:0]          rem_q, rem_d;
  logic [jacs_pkg::MAG_W-1:0]          dvs_q, dvs_d;
  logic [jacs_pkg::QUO_W-1:0]          quo_q, quo_d;
  logic [jacs_pkg::MAG_W-1:0]          trial;
  logic                                fits;

  assign trial = {rem_q[jacs_pkg::MAG_W-2:0], quo_q[jacs_pkg::QUO_W-1]};
  assign fits  = (trial >= dvs_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = jacs_pkg::FULL_SCALE;
    end else if (busy_q) begin
      rem_d = fits ? (trial - dvs_q) : trial;
      quo_d = {quo_q[jacs_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == jacs_pkg::STEP_CNT_W'(jacs_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* hdl/joystick_axis_calibrate_scale.sv */
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_scale
// per-channel joystick axis calibration: center capture, range tracking,
// gain computation and scaled conversion with clamping
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                          transaction
//  samp_i   in   operation, channel, raw_sample                   valid & ready
//  res_o    out  axis_value, neg_gain_out, pos_gain_out,          valid & ready
//                divide_by_zero
//
//  one item at a time: capture and track pass through exec to done, convert
//  adds a clamp step after the 16x16 multiply in exec, and finish runs the
//  bit-serial divider twice, once per gain
//  reset puts every channel at offset 0, gains 1 and empty range extremes
//  the result sits in an output register, so the next item is taken while
//  the previous result still waits; a stalled output only holds the
//  sequencer in its last state once a second result is ready
//
module joystick_axis_calibrate_scale #(
  parameter int unsigned CHANNELS = jacs_pkg::CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jacs_samp_if.sink samp_i,
  jacs_res_if.source res_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CLMP = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_DIVP = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  // accepted item
  logic [1:0]  op_q;
  logic [1:0]  ch_q;
  logic [15:0] raw_q;
  logic        hit_q;

  // per-channel calibration state
  logic        [15:0] off_q  [CHANNELS];
  logic signed [15:0] ngain_q[CHANNELS];
  logic signed [15:0] pgain_q[CHANNELS];
  logic signed [15:0] rmin_q [CHANNELS];
  logic signed [15:0] rmax_q [CHANNELS];

  // working results
  logic signed [31:0] prod_q;
  logic signed [15:0] axis_q;
  logic               flag_q;

  // output register
  logic               ovld_q;
  logic signed [15:0] oaxis_q, onegg_q, oposg_q;
  logic               oflag_q;

  logic [IDX_W-1:0]   idx;
  logic signed [15:0] diff;
  logic signed [15:0] gain_sel;
  logic signed [15:0] dmin, dmax;
  logic [jacs_pkg::MAG_W-1:0] mag_min, mag_max;
  logic signed [15:0] qsgn;
  logic               out_free;
  logic               samp_acc;

  jacs_pkg::div_req_t div_req;
  jacs_pkg::div_rsp_t div_rsp;

  assign idx      = IDX_W'(ch_q);
  assign diff     = signed'(raw_q - off_q[idx]);
  assign gain_sel = diff[15] ? ngain_q[idx] : pgain_q[idx];
  assign dmin     = rmin_q[idx];
  assign dmax     = rmax_q[idx];
  // magnitudes in 17 bits so that -32768 stays exact
  assign mag_min  = dmin[15] ? (jacs_pkg::MAG_W'(0) - {dmin[15], dmin})
                             : {dmin[15], dmin};
  assign mag_max  = dmax[15] ? (jacs_pkg::MAG_W'(0) - {dmax[15], dmax})
                             : {dmax[15], dmax};
  assign qsgn     = signed'({1'b0, div_rsp.quotient});

  assign out_free = !ovld_q || res_o.ready;
  assign samp_acc = samp_i.valid && samp_i.ready;
  assign samp_i.ready = (state_q == S_IDLE);

  // divider is started from the exec step (negative side) and again when the
  // first quotient comes back (positive side)
  always_comb begin
    div_req.start   = 1'b0;
    div_req.divisor = mag_min;
    if (state_q == S_EXEC && hit_q && op_q == jacs_pkg::OP_FINISH) begin
      div_req.start = 1'b1;
    end else if (state_q == S_DIVN && div_rsp.done) begin
      div_req.start   = 1'b1;
      div_req.divisor = mag_max;
    end
  end

  jacs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (samp_acc) state_d = S_EXEC;
      S_EXEC: begin
        if (!hit_q) begin
          state_d = S_DONE;
        end else begin
          case (op_q)
            jacs_pkg::OP_CONVERT: state_d = S_CLMP;
            jacs_pkg::OP_FINISH:  state_d = S_DIVN;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_CLMP: state_d = S_DONE;
      S_DIVN: if (div_rsp.done) state_d = S_DIVP;
      S_DIVP: if (div_rsp.done) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        off_q[i]   <= '0;
        ngain_q[i] <= jacs_pkg::GAIN_RST;
        pgain_q[i] <= jacs_pkg::GAIN_RST;
        rmin_q[i]  <= jacs_pkg::RANGE_MIN_RST;
        rmax_q[i]  <= jacs_pkg::RANGE_MAX_RST;
      end
    end else begin
      state_q <= state_d;

      // a new result replaces the one leaving in the same cycle
      if (state_q == S_DONE && out_free) ovld_q <= 1'b1;
      else if (ovld_q && res_o.ready)    ovld_q <= 1'b0;

      if (state_q == S_EXEC && hit_q) begin
        case (op_q)
          jacs_pkg::OP_CAPTURE: begin
            off_q[idx]  <= raw_q;
            rmin_q[idx] <= jacs_pkg::RANGE_MIN_RST;
            rmax_q[idx] <= jacs_pkg::RANGE_MAX_RST;
          end
          jacs_pkg::OP_TRACK: begin
            if (diff < dmin) rmin_q[idx] <= diff;
            if (diff > dmax) rmax_q[idx] <= diff;
          end
          default: ;
        endcase
      end

      // -32767 / min: negative when min is positive
      if (state_q == S_DIVN && div_rsp.done) begin
        if (dmin == 16'sd0)  ngain_q[idx] <= '0;
        else if (!dmin[15])  ngain_q[idx] <= -qsgn;
        else                 ngain_q[idx] <= qsgn;
      end

      // 32767 / max: negative when max is negative
      if (state_q == S_DIVP && div_rsp.done) begin
        if (dmax == 16'sd0)  pgain_q[idx] <= '0;
        else if (dmax[15])   pgain_q[idx] <= -qsgn;
        else                 pgain_q[idx] <= qsgn;
      end
    end
  end

  // item capture, working values and output payload
  always_ff @(posedge clk_i) begin
    if (samp_acc) begin
      op_q  <= samp_i.operation;
      ch_q  <= samp_i.channel;
      raw_q <= samp_i.raw_sample;
      hit_q <= (32'(samp_i.channel) < CHANNELS);
    end

    if (state_q == S_EXEC) begin
      prod_q <= 32'(diff) * 32'(gain_sel);
      flag_q <= 1'b0;
      axis_q <= (op_q == jacs_pkg::OP_TRACK && hit_q) ? diff : 16'sd0;
    end

    if (state_q == S_CLMP) begin
      if (prod_q > 32'(jacs_pkg::AXIS_POS))       axis_q <= jacs_pkg::AXIS_POS;
      else if (prod_q < 32'(jacs_pkg::AXIS_NEG))  axis_q <= jacs_pkg::AXIS_NEG;
      else                                        axis_q <= prod_q[15:0];
    end

    if ((state_q == S_DIVN || state_q == S_DIVP) && div_rsp.done) begin
      if (state_q == S_DIVN && dmin == 16'sd0) flag_q <= 1'b1;
      if (state_q == S_DIVP && dmax == 16'sd0) flag_q <= 1'b1;
    end

    if (state_q == S_DONE && out_free) begin
      oaxis_q <= axis_q;
      onegg_q <= hit_q ? ngain_q[idx] : 16'sd0;
      oposg_q <= hit_q ? pgain_q[idx] : 16'sd0;
      oflag_q <= flag_q;
    end
  end

  assign res_o.valid          = ovld_q;
  assign res_o.axis_value     = oaxis_q;
  assign res_o.neg_gain_out   = onegg_q;
  assign res_o.pos_gain_out   = oposg_q;
  assign res_o.divide_by_zero = oflag_q;

endmodule
